// ----- hw/rtl/twwq_pkg.sv -----
// ----------------------------------------------------------------------------
// twwq_pkg
// Shared types and constants for the threshold waiter wakeup queue.
// ----------------------------------------------------------------------------
package twwq_pkg;

  localparam int NUM_WAITERS = 64;
  localparam int NUM_CLASSES = 4;
  localparam int ID_W        = 6;
  localparam int CLS_W       = 2;
  localparam int POS_W       = 64;
  localparam int CNT_W       = $clog2(NUM_WAITERS + 1);
  localparam logic [POS_W-1:0] POS_ALL_ONES = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_WAKEUP = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_ADDED       = 3'd0,
    KIND_REMOVED     = 3'd1,
    KIND_NOT_WAITING = 3'd2,
    KIND_ALREADY     = 3'd3,
    KIND_WOKEN       = 3'd4,
    KIND_NONE        = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_t;

  // Candidate travelling along the cell chain.
  typedef struct packed {
    logic             found;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] target;
  } cand_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic             write;
    logic             clear;
    logic [ID_W-1:0]  id;
    logic [CLS_W-1:0] cls;
    logic [POS_W-1:0] target;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/threshold_waiter_wakeup_queue.sv -----
// ----------------------------------------------------------------------------
// threshold_waiter_wakeup_queue
// Per-class minimum queue of waiters with threshold wakeup.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one command item: add, remove or wakeup. m_* channel
//   gives result items; tlast marks the final result of a command.
//   Waiters sit in a chain of NUM_WAITERS cells. Finding the front of a class
//   passes a candidate down the chain, one cell per cycle, and a decide step
//   follows each lookup. An add or a remove that changes the table runs one
//   lookup. A wakeup that releases n waiters runs n + 1 lookups and gives
//   one result per released waiter; one that releases none gives one result.
//   An add of a waiting waiter, a remove of an idle one and a wakeup below
//   the class minimum answer without a lookup.
//   Commands are taken one at a time; s_tready is low until the last result
//   of the current command is taken. A stalled receiver holds the result in
//   the output register and the block waits.
//   Reset clears all waiters and sets every class minimum to all ones.
//   Unused operation codes are taken and produce no result.
// ----------------------------------------------------------------------------
module threshold_waiter_wakeup_queue
  import twwq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // operation[1:0], waiter_id[7:2], wait_class[9:8],
                                // position[73:10], zero[79:74]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // kind[2:0], woken_id[8:3], class_minimum[72:9],
                                // zero[79:73]
  output logic        m_tlast
);

  state_t state, state_next;

  logic [ID_W-1:0]  id;
  logic [CLS_W-1:0] cls;
  logic [POS_W-1:0] pos;
  logic             waking;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] least [NUM_CLASSES];

  logic [2:0]       out_kind;
  logic [ID_W-1:0]  out_id;
  logic [POS_W-1:0] out_min;

  cell_cmd_t cmd;
  logic      scan_en;
  cand_t     chain [NUM_WAITERS+1];
  logic [NUM_WAITERS-1:0] wait_vec;
  cand_t     front;
  logic      wake_hit;

  op_t              in_op;
  logic [ID_W-1:0]  in_id;
  logic [CLS_W-1:0] in_cls;
  logic [POS_W-1:0] in_pos;
  logic             in_cls_ok;
  logic             in_waiting;
  logic             in_below;

  // class of a waiter being removed, kept beside the cells
  logic [CLS_W-1:0] cls_tab [NUM_WAITERS];
  logic [CLS_W-1:0] rm_cls;

  logic unused_ok;

  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_WAITERS; i++) begin : g_cell
    twwq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (ID_W'(i)),
      .cmd      (cmd),
      .scan_en  (scan_en),
      .scan_cls (cls),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1]),
      .waiting  (wait_vec[i])
    );
  end

  assign in_op      = op_t'(s_tdata[1:0]);
  assign in_id      = s_tdata[7:2];
  assign in_cls     = s_tdata[9:8];
  assign in_pos     = s_tdata[73:10];
  assign in_cls_ok  = 32'(in_cls) < NUM_CLASSES;
  assign in_waiting = wait_vec[in_id];
  assign in_below   = in_pos != '0 && least[in_cls] > in_pos;

  assign s_tready = state == ST_IDLE;
  assign m_tdata  = {7'd0, out_min, out_id, out_kind};

  assign front    = chain[NUM_WAITERS];
  assign wake_hit = waking && front.found && (pos == '0 || front.target <= pos);

  always_comb begin
    state_next = state;
    cmd        = '0;
    scan_en    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (in_op)
            OP_ADD:    state_next = (in_cls_ok && !in_waiting) ? ST_SCAN : ST_OUT;
            OP_REMOVE: state_next = in_waiting ? ST_SCAN : ST_OUT;
            OP_WAKEUP: state_next = (!in_cls_ok || in_below) ? ST_OUT : ST_SCAN;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        scan_en = 1'b1;
        if (cnt == CNT_W'(NUM_WAITERS)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = (wake_hit && out_kind != KIND_WOKEN) ? ST_SCAN : ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) begin
          state_next = (m_tlast) ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_IDLE && s_tvalid) begin
      cmd.write  = in_op == OP_ADD && in_cls_ok && !in_waiting;
      cmd.clear  = in_op == OP_REMOVE;
      cmd.id     = in_id;
      cmd.cls    = in_cls;
      cmd.target = in_pos;
    end
    if (state == ST_DECIDE && wake_hit) begin
      cmd.clear = 1'b1;
      cmd.id    = front.id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      cls_tab[cmd.id] <= cmd.cls;
    end
    if (s_tvalid && s_tready) begin
      rm_cls <= cls_tab[in_id];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      cnt      <= '0;
      waking   <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        least[c] <= POS_ALL_ONES;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            id       <= in_id;
            cls      <= in_cls;
            pos      <= in_pos;
            waking   <= in_op == OP_WAKEUP;
            out_id   <= '0;
            m_tlast  <= 1'b1;
            cnt      <= '0;
            unique case (in_op)
              OP_ADD: begin
                if (!in_cls_ok) begin
                  out_kind <= KIND_NOT_WAITING;
                  out_min  <= POS_ALL_ONES;
                  m_tvalid <= 1'b1;
                end else if (in_waiting) begin
                  out_kind <= KIND_ALREADY;
                  out_min  <= least[in_cls];
                  m_tvalid <= 1'b1;
                end else begin
                  out_kind <= KIND_ADDED;
                end
              end
              OP_REMOVE: begin
                if (in_waiting) begin
                  out_kind <= KIND_REMOVED;
                end else begin
                  out_kind <= KIND_NOT_WAITING;
                  out_min  <= in_cls_ok ? least[in_cls] : POS_ALL_ONES;
                  m_tvalid <= 1'b1;
                end
              end
              OP_WAKEUP: begin
                out_kind <= KIND_NONE;
                if (!in_cls_ok) begin
                  out_min  <= POS_ALL_ONES;
                  m_tvalid <= 1'b1;
                end else if (in_below) begin
                  out_min  <= least[in_cls];
                  m_tvalid <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          cnt <= (cnt == CNT_W'(NUM_WAITERS)) ? '0 : cnt + 1'b1;
          // the wave started in the first scan cycle is not used
          if (cnt == '0 && out_kind == KIND_REMOVED) begin
            cls <= rm_cls;
          end
        end
        ST_DECIDE: begin
          if (wake_hit) begin
            // release the front; the one released before it goes out now
            id <= front.id;
            if (out_kind == KIND_WOKEN) begin
              out_id   <= id;
              out_min  <= front.target;
              m_tlast  <= 1'b0;
              m_tvalid <= 1'b1;
            end else begin
              out_kind <= KIND_WOKEN;
            end
          end else begin
            least[cls] <= front.found ? front.target : POS_ALL_ONES;
            out_min    <= front.found ? front.target : POS_ALL_ONES;
            if (out_kind == KIND_WOKEN) begin
              out_id <= id;
            end
            m_tvalid   <= 1'b1;
            m_tlast    <= 1'b1;
            waking     <= 1'b0;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign unused_ok = ^s_tdata[79:74];

endmodule

// ----- hw/rtl/twwq_cell.sv -----
// ----------------------------------------------------------------------------
// twwq_cell
// One waiter slot; compares its target with the passing candidate and hands
// the better one to the next cell.
// ----------------------------------------------------------------------------
module twwq_cell
  import twwq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [ID_W-1:0]  cell_id,
  input  cell_cmd_t        cmd,
  input  logic             scan_en,
  input  logic [CLS_W-1:0] scan_cls,
  input  cand_t            cand_in,
  output cand_t            cand_out,
  output logic             waiting
);

  logic [POS_W-1:0] target;
  logic [CLS_W-1:0] cls;
  logic             take;

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting <= 1'b0;
    end else if (cmd.write && cmd.id == cell_id) begin
      waiting <= 1'b1;
    end else if (cmd.clear && cmd.id == cell_id) begin
      waiting <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && cmd.id == cell_id) begin
      target <= cmd.target;
      cls    <= cmd.cls;
    end
  end

  // strict less keeps the lower waiter number on ties (scan runs upward)
  assign take = scan_en && waiting && cls == scan_cls &&
                (!cand_in.found || target < cand_in.target);

  always_ff @(posedge clk) begin
    if (take) begin
      cand_out <= '{found: 1'b1, id: cell_id, target: target};
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

// ----- hw/rtl/twwq_checker.sv -----
// ----------------------------------------------------------------------------
// twwq_checker
// Port-level checks for the threshold waiter wakeup queue.
// ----------------------------------------------------------------------------
module twwq_checker
  import twwq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result dropped while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while result pending");

  a_woken_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != KIND_WOKEN |-> m_tdata[8:3] == '0)
    else $error("id on non-woken result");

  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != KIND_WOKEN |-> m_tlast)
    else $error("single result without last");

endmodule

bind threshold_waiter_wakeup_queue twwq_checker u_twwq_checker (.*);

// ----- sim/tb_threshold_waiter_wakeup_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_waiter_wakeup_queue
// Drives add, remove and wakeup commands into the waiter queue, predicts the
// result items from a behavioral copy of the waiter table and checks every
// result field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_threshold_waiter_wakeup_queue;
  import twwq_pkg::*;

  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  woken_id;
    logic [POS_W-1:0] class_minimum;
    logic             last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;

  result_t          expected_results[$];
  bit               waiting[NUM_WAITERS];
  logic [POS_W-1:0] target_of[NUM_WAITERS];
  logic [CLS_W-1:0] class_of[NUM_WAITERS];
  logic [POS_W-1:0] least[NUM_CLASSES];
  int               errors = 0;
  longint           cycles = 0;

  threshold_waiter_wakeup_queue DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd200_000) begin
      $display("threshold_waiter_wakeup_queue: mismatch");
      $finish;
    end
  end

  function automatic int front_waiter(logic [CLS_W-1:0] c);
    int best = -1;
    for (int i = 0; i < NUM_WAITERS; i++)
      if (waiting[i] && class_of[i] == c)
        if (best < 0 || target_of[i] < target_of[best]) best = i;
    return best;
  endfunction

  function automatic void refresh_least(logic [CLS_W-1:0] c);
    int f = front_waiter(c);
    least[c] = (f < 0) ? POS_ALL_ONES : target_of[f];
  endfunction

  function automatic void push_result(kind_t k, int id, logic [POS_W-1:0] m, bit l);
    result_t r;
    r.kind = k;
    r.woken_id = id[ID_W-1:0];
    r.class_minimum = m;
    r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_queue(op_t op, logic [ID_W-1:0] id,
                                        logic [CLS_W-1:0] cls, logic [POS_W-1:0] pos);
    int n = 0;
    int f;
    logic [CLS_W-1:0] sc;
    case (op)
      OP_ADD: begin
        if (waiting[id]) begin
          push_result(KIND_ALREADY, 0, least[cls], 1'b1);
        end else begin
          waiting[id] = 1'b1;
          target_of[id] = pos;
          class_of[id] = cls;
          refresh_least(cls);
          push_result(KIND_ADDED, 0, least[cls], 1'b1);
        end
      end
      OP_REMOVE: begin
        if (waiting[id]) begin
          sc = class_of[id];
          waiting[id] = 1'b0;
          refresh_least(sc);
          push_result(KIND_REMOVED, 0, least[sc], 1'b1);
        end else begin
          push_result(KIND_NOT_WAITING, 0, least[cls], 1'b1);
        end
      end
      OP_WAKEUP: begin
        if (!(pos != 0 && least[cls] > pos)) begin
          forever begin
            f = front_waiter(cls);
            if (f < 0) break;
            if (pos != 0 && target_of[f] > pos) break;
            waiting[f] = 1'b0;
            refresh_least(cls);
            push_result(KIND_WOKEN, f, least[cls], 1'b0);
            n++;
          end
        end
        if (n == 0) push_result(KIND_NONE, 0, least[cls], 1'b1);
        else expected_results[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic send_command(op_t op, logic [ID_W-1:0] id, logic [CLS_W-1:0] cls,
                              logic [POS_W-1:0] pos);
    int gap = $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, pos, cls, id, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_queue(op, id, cls, pos);
  endtask

  always @(posedge clk) begin
    result_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = kind_t'(m_tdata[2:0]);
      got.woken_id = m_tdata[8:3];
      got.class_minimum = m_tdata[72:9];
      got.last = m_tlast;
      if (expected_results.size() == 0) begin
        $error("unexpected result item kind=%0d", got.kind);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.kind != exp_r.kind) begin
          $error("kind expected %0d got %0d", exp_r.kind, got.kind); errors++;
        end
        if (got.woken_id != exp_r.woken_id) begin
          $error("woken_id expected %0d got %0d", exp_r.woken_id, got.woken_id); errors++;
        end
        if (got.class_minimum != exp_r.class_minimum) begin
          $error("class_minimum expected %h got %h", exp_r.class_minimum,
                 got.class_minimum);
          errors++;
        end
        if (got.last != exp_r.last) begin
          $error("last expected %0d got %0d", exp_r.last, got.last); errors++;
        end
        if (m_tdata[79:73] != '0) begin
          $error("zero pad expected 0 got %h", m_tdata[79:73]); errors++;
        end
      end
    end
  end

  int rx_wait = 0;
  always @(posedge clk) begin
    int w;
    if (m_tready && m_tvalid) begin
      w = $urandom_range(0, 5);
      rx_wait <= w;
      m_tready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [POS_W-1:0] rand_pos();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_command(OP_WAKEUP, 6'd0, 2'd0, 64'd0);
    send_command(OP_REMOVE, 6'd63, 2'd3, 64'd0);
    send_command(OP_ADD, 6'd0, 2'd0, 64'd0);
    send_command(OP_ADD, 6'd63, 2'd0, POS_ALL_ONES);
    send_command(OP_ADD, 6'd5, 2'd0, 64'd100);
    send_command(OP_ADD, 6'd3, 2'd0, 64'd100);
    send_command(OP_ADD, 6'd5, 2'd1, 64'd1);
    send_command(OP_ADD, 6'd10, 2'd3, 64'h5555_5555_5555_5555);
    send_command(OP_ADD, 6'd42, 2'd2, 64'hAAAA_AAAA_AAAA_AAAA);
    send_command(OP_UNUSED, 6'h2A, 2'd1, 64'd7);
    send_command(OP_WAKEUP, 6'd0, 2'd3, 64'd5);
    send_command(OP_WAKEUP, 6'd21, 2'd0, 64'd100);
    send_command(OP_REMOVE, 6'd10, 2'd0, 64'd0);
    send_command(OP_REMOVE, 6'd10, 2'd1, 64'd0);
    send_command(OP_WAKEUP, 6'd63, 2'd0, POS_ALL_ONES);
    send_command(OP_WAKEUP, 6'd0, 2'd2, 64'd0);
    send_command(OP_WAKEUP, 6'd0, 2'd1, 64'd0);
  endtask

  task automatic test_random(int count);
    op_t op;
    logic [POS_W-1:0] pos;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: op = OP_ADD;
        5, 6:          op = OP_REMOVE;
        7, 8:          op = OP_WAKEUP;
        default:       op = op_t'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 5))
        0:       pos = rand_pos();
        1:       pos = (op == OP_WAKEUP) ? 64'd0 : POS_ALL_ONES;
        default: pos = 64'd1000 + $urandom_range(0, 200);
      endcase
      send_command(op, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)), pos);
    end
  endtask

  task automatic test_drain();
    for (int c = 0; c < NUM_CLASSES; c++) send_command(OP_WAKEUP, 6'd0, c[1:0], 64'd0);
  endtask

  initial begin
    for (int c = 0; c < NUM_CLASSES; c++) least[c] = POS_ALL_ONES;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(160);
    test_drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("threshold_waiter_wakeup_queue: match");
    else
      $display("threshold_waiter_wakeup_queue: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/twwq_pkg.sv
hw/rtl/twwq_cell.sv
hw/rtl/threshold_waiter_wakeup_queue.sv
hw/rtl/twwq_checker.sv
sim/tb_threshold_waiter_wakeup_queue.sv
